[rtl/fms_pkg.sv]
// ----------------------------------------------------------------------------
// fms_pkg
// Types, codes and constants shared by the flight mission supervisor.
// ----------------------------------------------------------------------------
package fms_pkg;

    localparam int CmdW   = 8;
    localparam int MvW    = 13;
    localparam int ModeW  = 4;
    localparam int ActW   = 3;
    localparam int CntW   = 8;
    localparam int AddrW  = 3;
    localparam int DataW  = 32;

    localparam logic [MvW-1:0]  LowMvReset    = 13'd3000;
    localparam logic [CntW-1:0] LowLimitReset = 8'd10;
    localparam logic [CntW-1:0] CntMax        = 8'd255;

    // command codes
    localparam logic [CmdW-1:0] CMD_IDENTIFY = 8'd0;
    localparam logic [CmdW-1:0] CMD_TAKEOFF  = 8'd1;
    localparam logic [CmdW-1:0] CMD_LAND     = 8'd2;
    localparam logic [CmdW-1:0] CMD_ESTOP    = 8'd3;
    localparam logic [CmdW-1:0] CMD_RETURN   = 8'd4;

    // modes
    localparam logic [ModeW-1:0] M_IDLE      = 4'd0;
    localparam logic [ModeW-1:0] M_IDENTIFY  = 4'd1;
    localparam logic [ModeW-1:0] M_TAKEOFF   = 4'd2;
    localparam logic [ModeW-1:0] M_LANDING   = 4'd3;
    localparam logic [ModeW-1:0] M_ESTOP     = 4'd4;
    localparam logic [ModeW-1:0] M_RETURN    = 4'd5;
    localparam logic [ModeW-1:0] M_EXPLORING = 4'd6;
    localparam logic [ModeW-1:0] M_CRASHING  = 4'd7;
    localparam logic [ModeW-1:0] M_CRASHED   = 4'd8;

    // actions
    localparam logic [ActW-1:0] A_NONE        = 3'd0;
    localparam logic [ActW-1:0] A_START       = 3'd1;
    localparam logic [ActW-1:0] A_UPDATE      = 3'd2;
    localparam logic [ActW-1:0] A_END         = 3'd3;
    localparam logic [ActW-1:0] A_RETURN_STEP = 3'd4;
    localparam logic [ActW-1:0] A_FORCE_END   = 3'd5;
    localparam logic [ActW-1:0] A_IDENTIFY    = 3'd6;

    // register indexes
    localparam logic REG_LOW_MV    = 1'b0;
    localparam logic REG_LOW_LIMIT = 1'b1;

    typedef struct packed {
        logic [CmdW-1:0] command_code;
        logic            tumbled;
        logic [MvW-1:0]  battery_mv;
        logic            start_succeeded;
        logic            home_reached;
    } t_in_item;

    typedef struct packed {
        logic [ModeW-1:0] mode_out;
        logic [ActW-1:0]  action;
        logic             battery_low;
    } t_out_item;

    typedef struct packed {
        logic [MvW-1:0]  low_voltage_mv;
        logic [CntW-1:0] low_tick_limit;
    } t_cfg;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [CntW-1:0]  low_tick_count;
    } t_state;

endpackage

[rtl/fms_cfg.sv]
// ----------------------------------------------------------------------------
// fms_cfg
// APB-style register file: low-voltage threshold and low-tick limit.
// ----------------------------------------------------------------------------
module fms_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [fms_pkg::AddrW-1:0] paddr,
    input  logic [fms_pkg::DataW-1:0] pwdata,
    output logic [fms_pkg::DataW-1:0] prdata,
    output logic                      pready,
    output fms_pkg::t_cfg             o_cfg
);
    import fms_pkg::*;

    logic [MvW-1:0]  r_low_mv;
    logic [CntW-1:0] r_low_limit;
    logic            wr_en;
    logic            reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_mv    <= LowMvReset;
            r_low_limit <= LowLimitReset;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LOW_MV:    r_low_mv    <= pwdata[MvW-1:0];
                REG_LOW_LIMIT: r_low_limit <= pwdata[CntW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LOW_MV:    prdata = {{(DataW-MvW){1'b0}}, r_low_mv};
            REG_LOW_LIMIT: prdata = {{(DataW-CntW){1'b0}}, r_low_limit};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.low_voltage_mv = r_low_mv;
    assign o_cfg.low_tick_limit = r_low_limit;

endmodule

[rtl/fms_step.sv]
// ----------------------------------------------------------------------------
// fms_step
// Mode transition logic for one tick: next mode, action, debounce counter.
// ----------------------------------------------------------------------------
module fms_step (
    input  fms_pkg::t_in_item  i_item,
    input  fms_pkg::t_state    i_state,
    input  fms_pkg::t_cfg      i_cfg,
    output fms_pkg::t_state    o_state,
    output fms_pkg::t_out_item o_result
);
    import fms_pkg::*;

    logic [ModeW-1:0] cmd_mode;
    logic [ModeW-1:0] cur_mode;
    logic [CntW-1:0]  eval_cnt;
    logic             eval_low;
    logic             is_low_tick;

    always_comb begin
        case (i_item.command_code)
            CMD_IDENTIFY: cmd_mode = M_IDENTIFY;
            CMD_TAKEOFF:  cmd_mode = M_TAKEOFF;
            CMD_LAND:     cmd_mode = M_LANDING;
            CMD_ESTOP:    cmd_mode = M_ESTOP;
            CMD_RETURN:   cmd_mode = M_RETURN;
            default:      cmd_mode = M_IDLE;
        endcase
    end

    // battery debounce, used only where the mode evaluates it
    assign is_low_tick = i_item.battery_mv < i_cfg.low_voltage_mv;
    always_comb begin
        if (!is_low_tick) begin
            eval_cnt = '0;
        end else if (i_state.low_tick_count == CntMax) begin
            eval_cnt = CntMax;
        end else begin
            eval_cnt = i_state.low_tick_count + 1'b1;
        end
    end
    assign eval_low = eval_cnt >= i_cfg.low_tick_limit;

    always_comb begin
        cur_mode = i_item.tumbled ? M_CRASHING : i_state.mode;
        if (cmd_mode == M_ESTOP) begin
            cur_mode = M_ESTOP;
        end

        o_state.mode           = M_IDLE;
        o_state.low_tick_count = i_state.low_tick_count;
        o_result.action        = A_NONE;
        o_result.battery_low   = 1'b0;

        case (cur_mode)
            M_IDLE: begin
                o_state.low_tick_count = eval_cnt;
                o_result.battery_low   = eval_low;
                o_state.mode = (eval_low && cmd_mode != M_IDENTIFY) ? M_IDLE : cmd_mode;
            end
            M_TAKEOFF: begin
                o_result.action = A_START;
                if (i_item.start_succeeded) begin
                    o_state.low_tick_count = '0;
                    o_state.mode           = M_EXPLORING;
                end else begin
                    o_state.mode = M_TAKEOFF;
                end
            end
            M_EXPLORING: begin
                o_result.action = A_UPDATE;
                if (cmd_mode == M_RETURN) begin
                    o_state.mode = M_RETURN;
                end else begin
                    o_state.low_tick_count = eval_cnt;
                    o_result.battery_low   = eval_low;
                    if (eval_low) begin
                        o_state.mode = M_RETURN;
                    end else if (cmd_mode == M_LANDING) begin
                        o_state.mode = M_LANDING;
                    end else begin
                        o_state.mode = M_EXPLORING;
                    end
                end
            end
            M_LANDING: begin
                o_result.action = A_END;
            end
            M_RETURN: begin
                o_result.action = A_RETURN_STEP;
                o_state.mode    = i_item.home_reached ? M_IDLE : M_RETURN;
            end
            M_ESTOP: begin
                o_result.action = A_FORCE_END;
            end
            M_IDENTIFY: begin
                o_result.action = A_IDENTIFY;
            end
            M_CRASHING: begin
                if (i_item.tumbled) begin
                    o_result.action = A_FORCE_END;
                    o_state.mode    = M_CRASHED;
                end
            end
            M_CRASHED: begin
                o_state.mode = i_item.tumbled ? M_CRASHED : M_IDLE;
            end
            default: begin
                o_state.mode = M_IDLE;
            end
        endcase

        o_result.mode_out = o_state.mode;
    end

endmodule

[rtl/flight_mission_supervisor_unit.sv]
// ----------------------------------------------------------------------------
// flight_mission_supervisor_unit
// Nine-mode vehicle supervisor, one tick per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready, i_in_item) takes one control tick per
//   item: command, tumble flag, battery voltage, start and return outcomes.
//   Output channel (o_valid/i_ready, o_out_item) returns one item per tick:
//   new mode, action to perform and the debounced low-battery flag.
//   Path from input accept to output valid: input register, mode logic,
//   result register. Throughput: one item per cycle while the receiver
//   does not stall.
//   Mode and debounce counter update when a tick moves into the result
//   register, so ticks are handled strictly in order.
//   When the receiver stalls, the result register holds and the input
//   register fills; o_ready drops only when both are occupied.
//   Reset (i_rst_n low, synchronous) empties both stages, sets mode to idle,
//   clears the counter and loads the register defaults (3000 mV, 10 ticks).
//   Registers: 0x0 low_voltage_mv, 0x4 low_tick_limit; write only while idle.
// ----------------------------------------------------------------------------
module flight_mission_supervisor_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  fms_pkg::t_in_item         i_in_item,
    output logic                      o_valid,
    input  logic                      i_ready,
    output fms_pkg::t_out_item        o_out_item,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [fms_pkg::AddrW-1:0] paddr,
    input  logic [fms_pkg::DataW-1:0] pwdata,
    output logic [fms_pkg::DataW-1:0] prdata,
    output logic                      pready
);
    import fms_pkg::*;

    t_cfg      cfg;
    t_in_item  r_in_item;
    logic      r_in_valid;
    t_out_item r_out_item;
    logic      r_out_valid;
    t_state    r_state;
    t_state    n_state;
    t_out_item n_out_item;
    logic      advance;
    logic      in_take;

    assign advance = r_in_valid & (~r_out_valid | i_ready);
    assign o_ready = ~r_in_valid | advance;
    assign in_take = i_valid & o_ready;

    fms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fms_step u_step (
        .i_item   (r_in_item),
        .i_state  (r_state),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{mode: M_IDLE, low_tick_count: '0};
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_item = r_out_item;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks flight_mission_supervisor_unit against a cycle-free mode predictor.
// A short table of ticks walks every mode and action. Then randomized ticks
// run under several threshold settings: a long idle soak that drives the
// debounce counter into saturation, the threshold extremes, a zero tick
// limit, and mission-shaped random traffic. Sender bursts and receiver
// stalls are random. Results are matched field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    import fms_pkg::*;

    localparam int QuietLimit = 400;

    typedef struct packed {
        t_in_item  it;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_valid    = 1'b0;
    logic               o_ready;
    t_in_item           i_in_item  = '0;
    logic               o_valid;
    logic               i_ready    = 1'b0;
    t_out_item          o_out_item;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [AddrW-1:0]   paddr      = '0;
    logic [DataW-1:0]   pwdata     = '0;
    logic [DataW-1:0]   prdata;
    logic               pready;

    // predictor state and thresholds
    logic [ModeW-1:0]   cur_mode      = M_IDLE;
    logic [CntW-1:0]    low_run       = '0;
    logic [MvW-1:0]     cfg_low_mv    = LowMvReset;
    logic [CntW-1:0]    cfg_low_limit = LowLimitReset;

    t_out_item          pending_results[$];
    t_dir_row           tick_table[$];
    t_out_item          head_result;
    int                 burst_left   = 0;
    int                 err_cnt      = 0;
    int                 quiet_cycles = 0;
    logic [8:0]         rx_cycle     = '0;

    flight_mission_supervisor_unit DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic debounce_battery(input logic [MvW-1:0] mv);
        if (mv < cfg_low_mv) begin
            if (low_run != CntMax) low_run = low_run + 1'b1;
        end else begin
            low_run = '0;
        end
        return low_run >= cfg_low_limit;
    endfunction

    function automatic t_out_item supervise_tick(input t_in_item it);
        logic [ModeW-1:0] next_mode;
        t_out_item        r;
        r = '0;
        r.action = A_NONE;
        if (it.tumbled) cur_mode = M_CRASHING;
        case (it.command_code)
            CMD_IDENTIFY: next_mode = M_IDENTIFY;
            CMD_TAKEOFF:  next_mode = M_TAKEOFF;
            CMD_LAND:     next_mode = M_LANDING;
            CMD_ESTOP:    next_mode = M_ESTOP;
            CMD_RETURN:   next_mode = M_RETURN;
            default:      next_mode = M_IDLE;
        endcase
        if (next_mode == M_ESTOP) cur_mode = M_ESTOP;
        case (cur_mode)
            M_IDLE: begin
                cur_mode = next_mode;
                r.battery_low = debounce_battery(it.battery_mv);
                if (r.battery_low && next_mode != M_IDENTIFY) cur_mode = M_IDLE;
            end
            M_TAKEOFF: begin
                r.action = A_START;
                if (it.start_succeeded) begin
                    low_run = '0;
                    cur_mode = M_EXPLORING;
                end
            end
            M_EXPLORING: begin
                // return command short-circuits the battery check
                if (next_mode == M_RETURN) begin
                    cur_mode = M_RETURN;
                end else begin
                    r.battery_low = debounce_battery(it.battery_mv);
                    if (r.battery_low) cur_mode = M_RETURN;
                    else if (next_mode == M_LANDING) cur_mode = M_LANDING;
                end
                r.action = A_UPDATE;
            end
            M_LANDING: begin
                r.action = A_END;
                cur_mode = M_IDLE;
            end
            M_RETURN: begin
                r.action = A_RETURN_STEP;
                if (it.home_reached) cur_mode = M_IDLE;
            end
            M_ESTOP: begin
                r.action = A_FORCE_END;
                cur_mode = M_IDLE;
            end
            M_IDENTIFY: begin
                r.action = A_IDENTIFY;
                cur_mode = M_IDLE;
            end
            M_CRASHING: begin
                if (it.tumbled) begin
                    r.action = A_FORCE_END;
                    cur_mode = M_CRASHED;
                end else begin
                    cur_mode = M_IDLE;
                end
            end
            M_CRASHED: begin
                if (!it.tumbled) cur_mode = M_IDLE;
            end
            default: cur_mode = M_IDLE;
        endcase
        r.mode_out = cur_mode;
        return r;
    endfunction

    function automatic t_dir_row tick_row(input logic [CmdW-1:0] cmd, input logic tmb,
                                          input logic [MvW-1:0] mv, input logic started,
                                          input logic home, input logic typed,
                                          input logic [ModeW-1:0] mode,
                                          input logic [ActW-1:0] act, input logic low);
        t_dir_row row;
        row.it.command_code    = cmd;
        row.it.tumbled         = tmb;
        row.it.battery_mv      = mv;
        row.it.start_succeeded = started;
        row.it.home_reached    = home;
        row.typed              = typed;
        row.want.mode_out      = mode;
        row.want.action        = act;
        row.want.battery_low   = low;
        return row;
    endfunction

    // soak: idle-heavy ticks with a low battery to saturate the counter
    function automatic t_in_item make_tick(input bit soak);
        t_in_item t;
        int       pick;
        int       lim;
        lim  = int'(cfg_low_mv);
        pick = $urandom_range(0, 15);
        if (soak) begin
            if (pick == 0) t.command_code = CMD_IDENTIFY;
            else if (pick == 1) t.command_code = CMD_ESTOP;
            else t.command_code = CmdW'($urandom_range(5, 255));
            t.tumbled = 1'b0;
            t.battery_mv = (lim > 0) ? MvW'($urandom_range(0, lim - 1)) : '0;
        end else begin
            if (pick < 5) t.command_code = CMD_TAKEOFF;
            else if (pick < 7) t.command_code = CMD_IDENTIFY;
            else if (pick == 7) t.command_code = CMD_LAND;
            else if (pick == 8) t.command_code = CMD_RETURN;
            else if (pick == 9) t.command_code = CMD_ESTOP;
            else t.command_code = CmdW'($urandom_range(0, 255));
            t.tumbled = ($urandom_range(0, 15) == 0);
            case ($urandom_range(0, 3))
                0: t.battery_mv = MvW'($urandom_range(0, 8191));
                3: t.battery_mv = MvW'($urandom_range(lim, 8191));
                default: t.battery_mv = (lim > 0) ? MvW'($urandom_range(0, lim - 1)) : '0;
            endcase
        end
        t.start_succeeded = 1'($urandom_range(0, 1));
        t.home_reached    = ($urandom_range(0, 3) == 0);
        return t;
    endfunction

    task automatic send_tick(input t_in_item it, input logic typed, input t_out_item want);
        t_out_item predicted;
        int        gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_ready);
        predicted = supervise_tick(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain_ticks();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DataW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_LOW_MV) cfg_low_mv = val[MvW-1:0];
        else cfg_low_limit = val[CntW-1:0];
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1'b1;
        case (rx_cycle[8:7])
            2'd0:    i_ready <= 1'b1;
            2'd1:    i_ready <= ($urandom_range(0, 3) != 0);
            2'd2:    i_ready <= rx_cycle[4];
            default: i_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item: mode_out %0d action %0d battery_low %0d",
                       o_out_item.mode_out, o_out_item.action, o_out_item.battery_low);
                err_cnt++;
            end else begin
                head_result = pending_results.pop_front();
                if (o_out_item.mode_out !== head_result.mode_out) begin
                    $error("mode_out: expected %0d, got %0d",
                           head_result.mode_out, o_out_item.mode_out);
                    err_cnt++;
                end
                if (o_out_item.action !== head_result.action) begin
                    $error("action: expected %0d, got %0d",
                           head_result.action, o_out_item.action);
                    err_cnt++;
                end
                if (o_out_item.battery_low !== head_result.battery_low) begin
                    $error("battery_low: expected %0d, got %0d",
                           head_result.battery_low, o_out_item.battery_low);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // walk through every mode with default thresholds
        tick_table.push_back(tick_row(CMD_IDENTIFY, 0, 8191, 0, 0, 1, M_IDENTIFY, A_NONE, 0));
        tick_table.push_back(tick_row(8'd255, 0, 8191, 1, 1, 1, M_IDLE, A_IDENTIFY, 0));
        tick_table.push_back(tick_row(CMD_TAKEOFF, 0, 8191, 0, 1, 1, M_TAKEOFF, A_NONE, 0));
        tick_table.push_back(tick_row(CMD_TAKEOFF, 0, 0, 0, 0, 1, M_TAKEOFF, A_START, 0));
        tick_table.push_back(tick_row(8'd255, 0, 0, 1, 0, 1, M_EXPLORING, A_START, 0));
        tick_table.push_back(tick_row(8'd255, 0, 8191, 0, 0, 1, M_EXPLORING, A_UPDATE, 0));
        tick_table.push_back(tick_row(CMD_RETURN, 0, 0, 0, 0, 1, M_RETURN, A_UPDATE, 0));
        tick_table.push_back(tick_row(8'd255, 0, 8191, 0, 0, 1, M_RETURN, A_RETURN_STEP, 0));
        tick_table.push_back(tick_row(8'd255, 0, 8191, 0, 1, 1, M_IDLE, A_RETURN_STEP, 0));
        tick_table.push_back(tick_row(CMD_TAKEOFF, 0, 8191, 0, 0, 1, M_TAKEOFF, A_NONE, 0));
        tick_table.push_back(tick_row(8'd255, 0, 8191, 1, 0, 1, M_EXPLORING, A_START, 0));
        tick_table.push_back(tick_row(CMD_LAND, 0, 8191, 0, 0, 1, M_LANDING, A_UPDATE, 0));
        tick_table.push_back(tick_row(CMD_LAND, 0, 8191, 0, 0, 1, M_IDLE, A_END, 0));
        tick_table.push_back(tick_row(CMD_ESTOP, 0, 8191, 0, 0, 1, M_IDLE, A_FORCE_END, 0));
        tick_table.push_back(tick_row(8'd255, 1, 8191, 0, 0, 1, M_CRASHED, A_FORCE_END, 0));
        tick_table.push_back(tick_row(CMD_RETURN, 1, 8191, 0, 1, 1, M_CRASHED, A_FORCE_END, 0));
        tick_table.push_back(tick_row(8'd128, 0, 8191, 0, 0, 1, M_IDLE, A_NONE, 0));
        tick_table.push_back(tick_row(CMD_ESTOP, 1, 0, 1, 1, 1, M_IDLE, A_FORCE_END, 0));
        // low ticks counted in idle, then cleared by a good reading
        tick_table.push_back(tick_row(8'h55, 0, 2999, 1, 1, 0, M_IDLE, A_NONE, 0));
        tick_table.push_back(tick_row(8'hAA, 0, 0, 0, 1, 0, M_IDLE, A_NONE, 0));
        tick_table.push_back(tick_row(8'hFF, 0, 13'h1555, 1, 0, 0, M_IDLE, A_NONE, 0));
        tick_table.push_back(tick_row(CMD_IDENTIFY, 0, 13'h0AAA, 0, 0, 0, M_IDLE, A_NONE, 0));
        tick_table.push_back(tick_row(8'hFF, 0, 3000, 0, 0, 0, M_IDLE, A_NONE, 0));
        tick_table.push_back(tick_row(CMD_TAKEOFF, 0, 2999, 1, 0, 0, M_IDLE, A_NONE, 0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (tick_table[k]) send_tick(tick_table[k].it, tick_table[k].typed, tick_table[k].want);

        for (int ph = 0; ph < 6; ph++) begin
            drain_ticks();
            case (ph)
                0: begin
                    write_reg(REG_LOW_MV, 8191);
                    write_reg(REG_LOW_LIMIT, 255);
                end
                1: begin
                    write_reg(REG_LOW_MV, 0);
                    write_reg(REG_LOW_LIMIT, 1);
                end
                2: begin
                    write_reg(REG_LOW_MV, 8191);
                    write_reg(REG_LOW_LIMIT, 1);
                end
                3: begin
                    write_reg(REG_LOW_MV, 4000);
                    write_reg(REG_LOW_LIMIT, 0);
                end
                default: begin
                    write_reg(REG_LOW_MV, $urandom_range(2000, 5000));
                    write_reg(REG_LOW_LIMIT, $urandom_range(1, 6));
                end
            endcase
            repeat ((ph == 0) ? 300 : 24) send_tick(make_tick(ph == 0), 1'b0, '0);
        end
        drain_ticks();

        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
